@@ hdl/lwnc_pkg.sv @@
// shared types and constants for the label window neighbour classifier
`default_nettype none

package lwnc_pkg;

    localparam int COORD_BITS     = 11;
    localparam int FRAME_BITS     = 12;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NLIMIT_BITS    = 4;
    localparam int CLIMIT_BITS    = 6;
    localparam int INC_BITS       = 2;
    localparam int MIN_FRAME      = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_FRAME_WIDTH     = 3'd0;
    localparam cfg_index_t REG_FRAME_HEIGHT    = 3'd1;
    localparam cfg_index_t REG_NEIGHBOUR_LIMIT = 3'd2;
    localparam cfg_index_t REG_COMBINED_LIMIT  = 3'd3;
    localparam cfg_index_t REG_PAIR_INCREMENT  = 3'd4;

    localparam logic [FRAME_BITS-1:0]         FRAME_WIDTH_RST     = 12'd640;
    localparam logic [FRAME_BITS-1:0]         FRAME_HEIGHT_RST    = 12'd480;
    localparam logic [NLIMIT_BITS-1:0]        NEIGHBOUR_LIMIT_RST = 4'd4;
    localparam logic signed [CLIMIT_BITS-1:0] COMBINED_LIMIT_RST  = 6'sd8;
    localparam logic signed [INC_BITS-1:0]    PAIR_INCREMENT_RST  = 2'sd1;

    // ring of neighbours: left, upper-left, up, upper-right, right,
    // lower-right, down, lower-left (window cell indices, row major)
    localparam int RING_LEN  = 8;
    localparam int RING_LAST = 7;
    localparam int RING_CELL [RING_LEN] = '{3, 0, 1, 2, 5, 8, 7, 6};
    localparam int CENTRE_CELL = 4;
    localparam int WIN_CELLS   = 9;

    typedef struct packed {
        logic [NLIMIT_BITS-1:0]        neighbour_limit;
        logic signed [CLIMIT_BITS-1:0] combined_limit;
        logic signed [INC_BITS-1:0]    pair_increment;
    } cls_cfg_t;

endpackage

`default_nettype wire

@@ hdl/lwnc_raster_ctr.sv @@
// raster position counters with frame size clamping
`default_nettype none

module lwnc_raster_ctr #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int COL_BITS   = 11,
    parameter int ROW_BITS   = 11
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            advance,
    input  wire logic [lwnc_pkg::FRAME_BITS-1:0] frame_width,
    input  wire logic [lwnc_pkg::FRAME_BITS-1:0] frame_height,
    output logic      [COL_BITS-1:0]             col,
    output logic      [ROW_BITS-1:0]             row
);

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [31:0]         w_clamp, h_clamp;
    logic                col_last, row_last;

    always_comb begin
        if (32'(frame_width) < 32'(lwnc_pkg::MIN_FRAME)) begin
            w_clamp = 32'(lwnc_pkg::MIN_FRAME);
        end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = 32'(frame_width);
        end
        if (32'(frame_height) < 32'(lwnc_pkg::MIN_FRAME)) begin
            h_clamp = 32'(lwnc_pkg::MIN_FRAME);
        end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
            h_clamp = 32'(MAX_HEIGHT);
        end else begin
            h_clamp = 32'(frame_height);
        end
    end

    // a counter at or past the last position wraps on its next advance
    assign col_last = (32'(col_reg) + 32'd1) >= w_clamp;
    assign row_last = (32'(row_reg) + 32'd1) >= h_clamp;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

endmodule

`default_nettype wire

@@ hdl/lwnc_line_buffer.sv @@
// upper and middle line stores, registered read, write on stage advance
`default_nettype none

module lwnc_line_buffer #(
    parameter int DEPTH     = 2048,
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 17
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_cell,
    output logic      [DATA_BITS-1:0] upper_rd,
    output logic      [DATA_BITS-1:0] middle_rd
);

    logic [DATA_BITS-1:0] upper_mem  [DEPTH];
    logic [DATA_BITS-1:0] middle_mem [DEPTH];
    logic [DATA_BITS-1:0] upper_rd_reg, middle_rd_reg;

    // the write address always differs from the read address in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
    end

    // the middle line moves up, the new pixel takes its place
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= middle_rd_reg;
            middle_mem[wr_addr] <= wr_cell;
        end
    end

    assign upper_rd  = upper_rd_reg;
    assign middle_rd = middle_rd_reg;

endmodule

`default_nettype wire

@@ hdl/lwnc_window_eval.sv @@
// 3x3 window registers, neighbour classification and result register
`default_nettype none

module lwnc_window_eval #(
    parameter int LABEL_BITS = 16,
    parameter int COL_BITS   = 11,
    parameter int ROW_BITS   = 11
) (
    input  wire logic                              aclk,
    input  wire logic                              advance,
    input  wire logic [LABEL_BITS:0]               upper_cell,
    input  wire logic [LABEL_BITS:0]               middle_cell,
    input  wire logic [LABEL_BITS:0]               new_cell,
    input  wire logic [ROW_BITS-1:0]               in_row,
    input  wire logic [COL_BITS-1:0]               in_col,
    input  wire lwnc_pkg::cls_cfg_t                cls_cfg,
    output logic                                   centre_valid,
    output logic      [lwnc_pkg::COORD_BITS-1:0]   centre_row,
    output logic      [lwnc_pkg::COORD_BITS-1:0]   centre_col,
    output logic      [LABEL_BITS-1:0]             centre_label,
    output logic                                   reassign_flag,
    output logic                                   moved_out
);

    logic [LABEL_BITS:0] win_reg  [lwnc_pkg::WIN_CELLS];
    logic [LABEL_BITS:0] win_next [lwnc_pkg::WIN_CELLS];

    logic [LABEL_BITS-1:0]            lbl;
    logic                             moved;
    logic [lwnc_pkg::RING_LEN-1:0]    same;
    logic [lwnc_pkg::RING_LEN-1:0]    pair_hit;
    logic [3:0]                       count;
    logic [3:0]                       npairs;
    logic signed [6:0]                pair_sum;
    logic signed [6:0]                total;
    logic                             interior;
    logic                             flag;
    logic [ROW_BITS-1:0]              row_m1;
    logic [COL_BITS-1:0]              col_m1;

    logic                             valid_reg;
    logic [lwnc_pkg::COORD_BITS-1:0]  row_reg, col_reg;
    logic [LABEL_BITS-1:0]            label_reg;
    logic                             flag_reg, moved_reg;

    // shift left, new column from the line stores and the incoming pixel
    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = upper_cell;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = middle_cell;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = new_cell;
    end

    always_comb begin
        lbl   = win_next[lwnc_pkg::CENTRE_CELL][LABEL_BITS-1:0];
        moved = win_next[lwnc_pkg::CENTRE_CELL][LABEL_BITS];
        for (int k = 0; k < lwnc_pkg::RING_LEN; k++) begin
            same[k] = win_next[lwnc_pkg::RING_CELL[k]][LABEL_BITS-1:0] == lbl;
        end
        for (int k = 0; k < lwnc_pkg::RING_LEN; k++) begin
            pair_hit[k] = same[k] & same[(k == lwnc_pkg::RING_LAST) ? 0 : k + 1];
        end
        count    = 4'($countones(same));
        npairs   = 4'($countones(pair_hit));
        pair_sum = $signed({3'b000, npairs})
                 * $signed({{5{cls_cfg.pair_increment[1]}}, cls_cfg.pair_increment});
        total    = $signed({3'b000, count}) + pair_sum;
        interior = (32'(in_row) >= 32'd2) && (32'(in_col) >= 32'd2);
        flag     = (lbl != '0) && (count <= cls_cfg.neighbour_limit)
                 && (total <= $signed({cls_cfg.combined_limit[5], cls_cfg.combined_limit}))
                 && !moved;
        row_m1   = in_row - ROW_BITS'(1);
        col_m1   = in_col - COL_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < lwnc_pkg::WIN_CELLS; k++) begin
                win_reg[k] <= win_next[k];
            end
            valid_reg <= interior;
            row_reg   <= interior ? lwnc_pkg::COORD_BITS'(row_m1) : '0;
            col_reg   <= interior ? lwnc_pkg::COORD_BITS'(col_m1) : '0;
            label_reg <= interior ? lbl : '0;
            flag_reg  <= interior & flag;
            moved_reg <= interior & (moved | flag);
        end
    end

    assign centre_valid  = valid_reg;
    assign centre_row    = row_reg;
    assign centre_col    = col_reg;
    assign centre_label  = label_reg;
    assign reassign_flag = flag_reg;
    assign moved_out     = moved_reg;

endmodule

`default_nettype wire

@@ hdl/label_window_neighbour_classifier_top.sv @@
// top level of the label window neighbour classifier
//
// Input channel s_*: one label pixel and its moved bit per transfer, in
// raster order across a frame of frame_width x frame_height pixels.
// Result channel m_*: one result per input pixel, describing the pixel one
// row and one column behind it; border centres come out with all fields zero.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index
// (0 frame_width, 1 frame_height, 2 neighbour_limit, 3 combined_limit,
// 4 pair_increment); write only while no transfer is in flight.
// A pixel that is taken is held in the input stage, then moves into the result
// register, from which it is offered on m_*.
// Throughput: one pixel per cycle while the result channel does not stall, set by
// the line store read issued as a pixel is taken, the line store write made as it
// leaves the input stage, and the registered window classification.
// When m_ready is low the result holds; one more pixel is still taken if the
// input stage is empty, after which s_ready drops until the result moves on.
// Reset clears the raster counters and both pipeline valid bits and loads the
// register defaults; the line stores need no clearing since each row is
// written before it is read.

`default_nettype none

module label_window_neighbour_classifier_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int LABEL_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lwnc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [lwnc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [LABEL_BITS-1:0]               s_pixel_label,
    input  wire logic                                s_moved_bit,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_centre_valid,
    output logic      [lwnc_pkg::COORD_BITS-1:0]     m_centre_row,
    output logic      [lwnc_pkg::COORD_BITS-1:0]     m_centre_col,
    output logic      [LABEL_BITS-1:0]               m_centre_label,
    output logic                                     m_reassign_flag,
    output logic                                     m_moved_out
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);

    logic [lwnc_pkg::FRAME_BITS-1:0] frame_width_reg, frame_height_reg;
    lwnc_pkg::cls_cfg_t              cls_cfg_reg;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [LABEL_BITS:0]   s1_cell_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic                  accept, advance;
    logic [COL_BITS-1:0]   cur_col;
    logic [ROW_BITS-1:0]   cur_row;
    logic [LABEL_BITS:0]   upper_rd, middle_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg             <= lwnc_pkg::FRAME_WIDTH_RST;
            frame_height_reg            <= lwnc_pkg::FRAME_HEIGHT_RST;
            cls_cfg_reg.neighbour_limit <= lwnc_pkg::NEIGHBOUR_LIMIT_RST;
            cls_cfg_reg.combined_limit  <= lwnc_pkg::COMBINED_LIMIT_RST;
            cls_cfg_reg.pair_increment  <= lwnc_pkg::PAIR_INCREMENT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lwnc_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata;
                end
                lwnc_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata;
                end
                lwnc_pkg::REG_NEIGHBOUR_LIMIT: begin
                    cls_cfg_reg.neighbour_limit <= cfg_wdata[lwnc_pkg::NLIMIT_BITS-1:0];
                end
                lwnc_pkg::REG_COMBINED_LIMIT: begin
                    cls_cfg_reg.combined_limit <= $signed(cfg_wdata[lwnc_pkg::CLIMIT_BITS-1:0]);
                end
                lwnc_pkg::REG_PAIR_INCREMENT: begin
                    cls_cfg_reg.pair_increment <= $signed(cfg_wdata[lwnc_pkg::INC_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // input stage moves on whenever the result register is free or draining
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cell_reg <= {s_moved_bit, s_pixel_label};
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
        end
    end

    lwnc_raster_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_BITS   (COL_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_raster_ctr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (cur_col),
        .row          (cur_row)
    );

    lwnc_line_buffer #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (LABEL_BITS + 1)
    ) u_line_buffer (
        .aclk      (aclk),
        .rd_en     (accept),
        .rd_addr   (cur_col),
        .wr_en     (advance),
        .wr_addr   (s1_col_reg),
        .wr_cell   (s1_cell_reg),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    lwnc_window_eval #(
        .LABEL_BITS (LABEL_BITS),
        .COL_BITS   (COL_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_window_eval (
        .aclk          (aclk),
        .advance       (advance),
        .upper_cell    (upper_rd),
        .middle_cell   (middle_rd),
        .new_cell      (s1_cell_reg),
        .in_row        (s1_row_reg),
        .in_col        (s1_col_reg),
        .cls_cfg       (cls_cfg_reg),
        .centre_valid  (m_centre_valid),
        .centre_row    (m_centre_row),
        .centre_col    (m_centre_col),
        .centre_label  (m_centre_label),
        .reassign_flag (m_reassign_flag),
        .moved_out     (m_moved_out)
    );

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ hdl/lwnc_checker.sv @@
// port-level checks for the classifier top level, with bind
`default_nettype none

module lwnc_checker #(
    parameter int LABEL_BITS = 16
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_centre_valid,
    input wire logic [lwnc_pkg::COORD_BITS-1:0] m_centre_row,
    input wire logic [lwnc_pkg::COORD_BITS-1:0] m_centre_col,
    input wire logic [LABEL_BITS-1:0]           m_centre_label,
    input wire logic                            m_reassign_flag,
    input wire logic                            m_moved_out
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_centre_row)
            && $stable(m_centre_col) && $stable(m_centre_label)
            && $stable(m_reassign_flag) && $stable(m_moved_out))
        else $error("result changed while stalled");

    // no result is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // border centres carry an all-zero result
    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_centre_valid |-> m_centre_row == '0 && m_centre_col == '0
            && m_centre_label == '0 && !m_reassign_flag && !m_moved_out)
        else $error("border result not zero");

    // a flag needs an interior centre with a nonzero label and sets moved
    a_flag_cond: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reassign_flag |-> m_centre_valid && m_moved_out
            && m_centre_label != '0 && m_centre_row != '0 && m_centre_col != '0)
        else $error("flag on invalid centre");

endmodule

bind label_window_neighbour_classifier_top lwnc_checker #(
    .LABEL_BITS (LABEL_BITS)
) u_lwnc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_centre_valid  (m_centre_valid),
    .m_centre_row    (m_centre_row),
    .m_centre_col    (m_centre_col),
    .m_centre_label  (m_centre_label),
    .m_reassign_flag (m_reassign_flag),
    .m_moved_out     (m_moved_out)
);

`default_nettype wire
